@@ src/first_fit_range_allocator_core_assert.svh @@
// assertion macros for the range allocator checker
`ifndef FIRST_FIT_RANGE_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define FFRA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define FFRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ffra_pkg.sv @@
// shared types and codes for the range allocator
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;

   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_BASE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LIMIT = 1'd1;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage
`default_nettype wire

@@ src/ffra_mem.sv @@
// range table memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ffra_mem
   import ffra_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 96
) (
   input  wire logic                     clock,
   input  wire mem_ctl_type              ctl,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/ffra_ctrl.sv @@
// sequencer: table scan, entry shifting and write-back
`timescale 1ns / 1ps
`default_nettype none
module ffra_ctrl
   import ffra_pkg::*;
#(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_command,
   input  wire logic [ADDR_BITS-1:0]          req_address,
   input  wire logic [ADDR_BITS-1:0]          req_length,
   input  wire logic [ADDR_BITS-1:0]          win_base,
   input  wire logic [ADDR_BITS-1:0]          win_limit,
   output logic                               done_valid,
   input  wire logic                          done_ready,
   output logic      [ADDR_BITS-1:0]          done_start,
   output logic      [1:0]                    done_status,
   output mem_ctl_type                        mem_ctl,
   output logic      [$clog2(MAX_RANGES)-1:0] mem_rd_addr,
   output logic      [$clog2(MAX_RANGES)-1:0] mem_wr_addr,
   output logic      [2*ADDR_BITS-1:0]        mem_wr_data,
   input  wire logic [2*ADDR_BITS-1:0]        mem_rd_data
);

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_OPEN, S_CLOSE, S_WRITE, S_WRITE2, S_DONE
   } state_type;

   state_type            state_ff;
   logic                 cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff, len_ff, stop_ff, base_ff;
   logic [ADDR_BITS-1:0] w_b_ff, w_e_ff, hit_e_ff;
   logic [IW-1:0]        pos_ff, chk_idx_ff;
   logic [CW-1:0]        sh_ff, count_ff;
   logic                 chk_valid_ff, split_ff, grow_ff;
   logic [ADDR_BITS-1:0] res_start_ff;
   logic [1:0]           res_status_ff;

   logic [ADDR_BITS-1:0] ent_b, ent_e;
   logic [ADDR_BITS:0]   free_sum;
   logic                 gap_fit, lim_fit, free_hit;

   assign ent_b    = mem_rd_data[2*ADDR_BITS-1:ADDR_BITS];
   assign ent_e    = mem_rd_data[ADDR_BITS-1:0];
   assign free_sum = {1'b0, req_address} + {1'b0, req_length};
   assign gap_fit  = (ent_b >= base_ff) && ((ent_b - base_ff) >= len_ff);
   assign lim_fit  = (win_limit >= base_ff) && ((win_limit - base_ff) >= len_ff);
   assign free_hit = (ent_b <= addr_ff) && (stop_ff <= ent_e);

   assign req_ready   = (state_ff == S_IDLE);
   assign done_valid  = (state_ff == S_DONE);
   assign done_start  = res_start_ff;
   assign done_status = res_status_ff;

   // memory port steering
   always_comb begin
      mem_ctl     = '0;
      mem_rd_addr = sh_ff[IW-1:0];
      mem_wr_addr = chk_idx_ff;
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         S_SCAN: begin
            mem_ctl.rd_en = (sh_ff < count_ff);
         end
         S_OPEN: begin
            mem_ctl.rd_en = (sh_ff > CW'(pos_ff));
            mem_rd_addr   = IW'(sh_ff - CW'(1));
            mem_ctl.wr_en = chk_valid_ff;
            mem_wr_addr   = chk_idx_ff + IW'(1);
         end
         S_CLOSE: begin
            mem_ctl.rd_en = (sh_ff < count_ff);
            mem_ctl.wr_en = chk_valid_ff;
            mem_wr_addr   = chk_idx_ff - IW'(1);
         end
         S_WRITE: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = pos_ff;
            mem_wr_data   = {w_b_ff, w_e_ff};
         end
         S_WRITE2: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = pos_ff + IW'(1);
            mem_wr_data   = {stop_ff, hit_e_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff       <= req_command;
                  addr_ff      <= req_address;
                  len_ff       <= req_length;
                  stop_ff      <= free_sum[ADDR_BITS-1:0];
                  base_ff      <= win_base;
                  sh_ff        <= '0;
                  chk_valid_ff <= 1'b0;
                  split_ff     <= 1'b0;
                  grow_ff      <= 1'b0;
                  res_start_ff <= '0;
                  if (req_command == CMD_FREE && free_sum[ADDR_BITS]) begin
                     res_status_ff <= ST_NOTFOUND;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               chk_valid_ff <= mem_ctl.rd_en;
               chk_idx_ff   <= sh_ff[IW-1:0];
               if (mem_ctl.rd_en) begin
                  sh_ff <= sh_ff + CW'(1);
               end
               if (chk_valid_ff) begin
                  if (cmd_ff == CMD_ALLOC) begin
                     if (gap_fit) begin
                        pos_ff       <= chk_idx_ff;
                        chk_valid_ff <= 1'b0;
                        w_b_ff       <= base_ff;
                        w_e_ff       <= base_ff + len_ff;
                        grow_ff      <= 1'b1;
                        sh_ff        <= count_ff;
                        if (count_ff >= MAX_CNT) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           res_start_ff  <= base_ff;
                           res_status_ff <= ST_OK;
                           state_ff      <= S_OPEN;
                        end
                     end else if (ent_e > base_ff) begin
                        base_ff <= ent_e;
                     end
                  end else if (free_hit) begin
                     pos_ff        <= chk_idx_ff;
                     chk_valid_ff  <= 1'b0;
                     hit_e_ff      <= ent_e;
                     res_status_ff <= ST_OK;
                     if (ent_b == addr_ff && ent_e == stop_ff) begin
                        sh_ff    <= CW'(chk_idx_ff) + CW'(1);
                        state_ff <= S_CLOSE;
                     end else if (ent_b == addr_ff) begin
                        w_b_ff   <= stop_ff;
                        w_e_ff   <= ent_e;
                        state_ff <= S_WRITE;
                     end else if (ent_e == stop_ff) begin
                        w_b_ff   <= ent_b;
                        w_e_ff   <= addr_ff;
                        state_ff <= S_WRITE;
                     end else if (count_ff >= MAX_CNT) begin
                        res_status_ff <= ST_FULL;
                        state_ff      <= S_DONE;
                     end else begin
                        // strict inside: split in two
                        w_b_ff   <= ent_b;
                        w_e_ff   <= addr_ff;
                        split_ff <= 1'b1;
                        grow_ff  <= 1'b1;
                        sh_ff    <= count_ff;
                        state_ff <= S_OPEN;
                     end
                  end
               end else if (!mem_ctl.rd_en) begin
                  // scan exhausted
                  if (cmd_ff == CMD_ALLOC && lim_fit) begin
                     pos_ff  <= IW'(count_ff);
                     w_b_ff  <= base_ff;
                     w_e_ff  <= base_ff + len_ff;
                     grow_ff <= 1'b1;
                     if (count_ff >= MAX_CNT) begin
                        res_status_ff <= ST_FULL;
                        state_ff      <= S_DONE;
                     end else begin
                        res_start_ff  <= base_ff;
                        res_status_ff <= ST_OK;
                        state_ff      <= S_WRITE;
                     end
                  end else begin
                     res_status_ff <= (cmd_ff == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_OPEN: begin
               chk_valid_ff <= mem_ctl.rd_en;
               chk_idx_ff   <= mem_rd_addr;
               if (mem_ctl.rd_en) begin
                  sh_ff <= sh_ff - CW'(1);
               end else if (!chk_valid_ff) begin
                  state_ff <= S_WRITE;
               end
            end
            S_CLOSE: begin
               chk_valid_ff <= mem_ctl.rd_en;
               chk_idx_ff   <= sh_ff[IW-1:0];
               if (mem_ctl.rd_en) begin
                  sh_ff <= sh_ff + CW'(1);
               end else if (!chk_valid_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_WRITE: begin
               if (grow_ff) begin
                  count_ff <= count_ff + CW'(1);
               end
               state_ff <= split_ff ? S_WRITE2 : S_DONE;
            end
            S_WRITE2: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (done_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ src/first_fit_range_allocator_core.sv @@
// top level of the first-fit address range allocator
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   req_     | req_valid / req_ready | command, address, length
//   rsp_     | rsp_valid / rsp_ready | start_address, status
//   csr_     | csr_we (no wait)      | csr_index, csr_wdata
//
// one request at a time; the scan stops at the chosen entry and the
// shift covers the rest, all through the single read port of the range
// table memory
// reset clears the entry count, the window registers and control state only, no memory sweep
// a finished result waits in the response register while the next
// request is taken; the sequencer holds only when that register is full
`timescale 1ns / 1ps
`default_nettype none
module first_fit_range_allocator_core
   import ffra_pkg::*;
#(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_command,
   input  wire logic [ADDR_BITS-1:0]      req_address,
   input  wire logic [ADDR_BITS-1:0]      req_length,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [ADDR_BITS-1:0]      rsp_start_address,
   output logic      [1:0]                rsp_status,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ADDR_BITS-1:0]      csr_wdata
);

   localparam int IW = $clog2(MAX_RANGES);

   // window registers
   logic [ADDR_BITS-1:0] win_base_ff, win_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_base_ff  <= '0;
         win_limit_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_BASE:  win_base_ff  <= csr_wdata;
            REG_WINDOW_LIMIT: win_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer to memory
   mem_ctl_type             mem_ctl;
   logic [IW-1:0]           mem_rd_addr, mem_wr_addr;
   logic [2*ADDR_BITS-1:0]  mem_wr_data, mem_rd_data;

   // sequencer to response register
   logic                    done_valid, done_ready;
   logic [ADDR_BITS-1:0]    done_start;
   logic [1:0]              done_status;

   ffra_ctrl #(
      .MAX_RANGES (MAX_RANGES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_address (req_address),
      .req_length  (req_length),
      .win_base    (win_base_ff),
      .win_limit   (win_limit_ff),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_start  (done_start),
      .done_status (done_status),
      .mem_ctl     (mem_ctl),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // begin in the upper half of a word, end in the lower
   ffra_mem #(
      .DEPTH (MAX_RANGES),
      .WIDTH (2 * ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // response register
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_start_ff;
   logic [1:0]           rsp_status_ff;

   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ready && done_valid) begin
         rsp_start_ff  <= done_start;
         rsp_status_ff <= done_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_start_address = rsp_start_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
`default_nettype wire

@@ src/ffra_checker.sv @@
// port-level checks for the range allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_range_allocator_core_assert.svh"
module ffra_checker
   import ffra_pkg::*;
#(
   parameter int ADDR_BITS = 48
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [ADDR_BITS-1:0] rsp_start_address,
   input wire logic [1:0]           rsp_status
);

   `FFRA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_start_address == '0, "failed request carries a start address")
   `FFRA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while another is in work")
   `FFRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_start_address), "stalled response changed")

endmodule

bind first_fit_range_allocator_core ffra_checker #(
   .ADDR_BITS (ADDR_BITS)
) u_ffra_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_start_address (rsp_start_address),
   .rsp_status        (rsp_status)
);
`default_nettype wire
